@@ rtl/orot_pkg.sv @@
// Shared constants for the oriented rectangle overlap test.
package orot_pkg;
  localparam int TRIG_FRAC_BITS_DEF = 14;
  localparam int POS_W  = 16;
  localparam int TRIG_W = 16;
  localparam int SIZE_W = 12;
  localparam int LATENCY = 5;
  localparam int NUM_AXES = 4;
  localparam int NUM_CORNERS = 4;
endpackage

@@ rtl/oriented_rect_overlap_test_core.sv @@
// Top level of the oriented rectangle overlap test.
//
// channel  | handshake                | payload
// request  | start (taken when !busy) | a_*, b_* box fields
// result   | done, one-cycle strobe   | hit
//
// One request enters per cycle; busy is always low. The result strobes
// done after the request has passed 2 stages corner build,
// 1 stage projection multipliers and 2 stages extent and compare.
// Synchronous reset clears the valid pipeline; requests in flight drop.
// The receiver cannot stall, so the pipeline never holds.
module oriented_rect_overlap_test_core
  import orot_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [POS_W-1:0]  a_pos_x,
  input  logic signed [POS_W-1:0]  a_pos_y,
  input  logic signed [TRIG_W-1:0] a_cos,
  input  logic signed [TRIG_W-1:0] a_sin,
  input  logic [SIZE_W-1:0]        a_width,
  input  logic [SIZE_W-1:0]        a_height,
  input  logic signed [POS_W-1:0]  b_pos_x,
  input  logic signed [POS_W-1:0]  b_pos_y,
  input  logic signed [TRIG_W-1:0] b_cos,
  input  logic signed [TRIG_W-1:0] b_sin,
  input  logic [SIZE_W-1:0]        b_width,
  input  logic [SIZE_W-1:0]        b_height,
  output logic                     done,
  output logic                     hit
);
  localparam int OW = SIZE_W + TRIG_W + 1;
  localparam int DW = POS_W + 1 + TRIG_FRAC_BITS;
  localparam int CW = ((DW > OW + 1) ? DW : OW + 1) + 1;
  localparam int AW = OW + 1;
  localparam int PW = CW + AW + 1;

  logic cg_valid, pj_valid;
  logic signed [NUM_CORNERS-1:0][CW-1:0] a_cx, a_cy, b_cx, b_cy;
  logic signed [NUM_AXES-1:0][AW-1:0] ax, ay;
  logic signed [NUM_AXES-1:0][NUM_CORNERS-1:0][PW-1:0] pa, pb;

  assign busy = 1'b0;

  orot_corner_gen #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .CW(CW), .AW(AW)) u_corner (
    .clk, .rst, .in_valid(start && !busy),
    .a_pos_x, .a_pos_y, .a_cos, .a_sin, .a_width, .a_height,
    .b_pos_x, .b_pos_y, .b_cos, .b_sin, .b_width, .b_height,
    .out_valid(cg_valid), .a_cx, .a_cy, .b_cx, .b_cy, .ax, .ay
  );

  orot_project #(.CW(CW), .AW(AW), .PW(PW)) u_project (
    .clk, .rst, .in_valid(cg_valid), .a_cx, .a_cy, .b_cx, .b_cy, .ax, .ay,
    .out_valid(pj_valid), .pa, .pb
  );

  orot_sep #(.PW(PW)) u_sep (
    .clk, .rst, .in_valid(pj_valid), .pa, .pb, .done, .hit
  );
endmodule

@@ rtl/orot_corner_gen.sv @@
// Corner and edge-axis generation: two register stages.
module orot_corner_gen
  import orot_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  parameter int CW = 32,
  parameter int AW = 30
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic signed [POS_W-1:0]   a_pos_x,
  input  logic signed [POS_W-1:0]   a_pos_y,
  input  logic signed [TRIG_W-1:0]  a_cos,
  input  logic signed [TRIG_W-1:0]  a_sin,
  input  logic [SIZE_W-1:0]         a_width,
  input  logic [SIZE_W-1:0]         a_height,
  input  logic signed [POS_W-1:0]   b_pos_x,
  input  logic signed [POS_W-1:0]   b_pos_y,
  input  logic signed [TRIG_W-1:0]  b_cos,
  input  logic signed [TRIG_W-1:0]  b_sin,
  input  logic [SIZE_W-1:0]         b_width,
  input  logic [SIZE_W-1:0]         b_height,
  output logic                      out_valid,
  output logic signed [NUM_CORNERS-1:0][CW-1:0] a_cx,
  output logic signed [NUM_CORNERS-1:0][CW-1:0] a_cy,
  output logic signed [NUM_CORNERS-1:0][CW-1:0] b_cx,
  output logic signed [NUM_CORNERS-1:0][CW-1:0] b_cy,
  output logic signed [NUM_AXES-1:0][AW-1:0]    ax,
  output logic signed [NUM_AXES-1:0][AW-1:0]    ay
);
  localparam int OW = SIZE_W + TRIG_W + 1;
  localparam int DW = POS_W + 1 + TRIG_FRAC_BITS;

  logic valid1;
  logic signed [OW-1:0] wca, wsa, hsa, hca, wcb, wsb, hsb, hcb;
  logic signed [DW-1:0] dx, dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid1 <= in_valid;
      out_valid <= valid1;
    end
  end

  // Stage 1: edge products and origin delta (scaled into trig units).
  always_ff @(posedge clk) begin
    wca <= $signed({1'b0, a_width}) * a_cos;
    wsa <= $signed({1'b0, a_width}) * a_sin;
    hsa <= $signed({1'b0, a_height}) * a_sin;
    hca <= $signed({1'b0, a_height}) * a_cos;
    wcb <= $signed({1'b0, b_width}) * b_cos;
    wsb <= $signed({1'b0, b_width}) * b_sin;
    hsb <= $signed({1'b0, b_height}) * b_sin;
    hcb <= $signed({1'b0, b_height}) * b_cos;
    dx  <= $signed({($signed({b_pos_x[POS_W-1], b_pos_x})
                   - $signed({a_pos_x[POS_W-1], a_pos_x})), {TRIG_FRAC_BITS{1'b0}}});
    dy  <= $signed({($signed({b_pos_y[POS_W-1], b_pos_y})
                   - $signed({a_pos_y[POS_W-1], a_pos_y})), {TRIG_FRAC_BITS{1'b0}}});
  end

  // Stage 2: corners relative to the first box origin, and the four axes.
  always_ff @(posedge clk) begin
    a_cx[0] <= '0;
    a_cy[0] <= '0;
    a_cx[1] <= CW'(wca);
    a_cy[1] <= CW'(wsa);
    a_cx[2] <= CW'(wca) - CW'(hsa);
    a_cy[2] <= CW'(wsa) + CW'(hca);
    a_cx[3] <= -CW'(hsa);
    a_cy[3] <= CW'(hca);
    b_cx[0] <= CW'(dx);
    b_cy[0] <= CW'(dy);
    b_cx[1] <= CW'(dx) + CW'(wcb);
    b_cy[1] <= CW'(dy) + CW'(wsb);
    b_cx[2] <= CW'(dx) + CW'(wcb) - CW'(hsb);
    b_cy[2] <= CW'(dy) + CW'(wsb) + CW'(hcb);
    b_cx[3] <= CW'(dx) - CW'(hsb);
    b_cy[3] <= CW'(dy) + CW'(hcb);
    ax[0] <= AW'(wca);
    ay[0] <= AW'(wsa);
    ax[1] <= AW'(hsa);
    ay[1] <= -AW'(hca);
    ax[2] <= AW'(hsb);
    ay[2] <= -AW'(hcb);
    ax[3] <= -AW'(wcb);
    ay[3] <= -AW'(wsb);
  end
endmodule

@@ rtl/orot_project.sv @@
// Projection of all corners onto the four axes: one register stage.
module orot_project
  import orot_pkg::*;
#(
  parameter int CW = 32,
  parameter int AW = 30,
  parameter int PW = 63
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic signed [NUM_CORNERS-1:0][CW-1:0] a_cx,
  input  logic signed [NUM_CORNERS-1:0][CW-1:0] a_cy,
  input  logic signed [NUM_CORNERS-1:0][CW-1:0] b_cx,
  input  logic signed [NUM_CORNERS-1:0][CW-1:0] b_cy,
  input  logic signed [NUM_AXES-1:0][AW-1:0]    ax,
  input  logic signed [NUM_AXES-1:0][AW-1:0]    ay,
  output logic out_valid,
  output logic signed [NUM_AXES-1:0][NUM_CORNERS-1:0][PW-1:0] pa,
  output logic signed [NUM_AXES-1:0][NUM_CORNERS-1:0][PW-1:0] pb
);
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_AXES; k++) begin
      for (int i = 0; i < NUM_CORNERS; i++) begin
        pa[k][i] <= PW'($signed(a_cx[i]) * $signed(ax[k]))
                  + PW'($signed(a_cy[i]) * $signed(ay[k]));
        pb[k][i] <= PW'($signed(b_cx[i]) * $signed(ax[k]))
                  + PW'($signed(b_cy[i]) * $signed(ay[k]));
      end
    end
  end
endmodule

@@ rtl/orot_sep.sv @@
// Interval extents and separation decision: two register stages.
module orot_sep
  import orot_pkg::*;
#(
  parameter int PW = 63
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic signed [NUM_AXES-1:0][NUM_CORNERS-1:0][PW-1:0] pa,
  input  logic signed [NUM_AXES-1:0][NUM_CORNERS-1:0][PW-1:0] pb,
  output logic done,
  output logic hit
);
  logic valid4;
  logic signed [NUM_AXES-1:0][PW-1:0] loa, hia, lob, hib;
  logic signed [NUM_AXES-1:0][PW-1:0] loa_next, hia_next, lob_next, hib_next;

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      loa_next[k] = pa[k][0];
      hia_next[k] = pa[k][0];
      lob_next[k] = pb[k][0];
      hib_next[k] = pb[k][0];
      for (int i = 1; i < NUM_CORNERS; i++) begin
        if ($signed(pa[k][i]) < $signed(loa_next[k])) loa_next[k] = pa[k][i];
        if ($signed(pa[k][i]) > $signed(hia_next[k])) hia_next[k] = pa[k][i];
        if ($signed(pb[k][i]) < $signed(lob_next[k])) lob_next[k] = pb[k][i];
        if ($signed(pb[k][i]) > $signed(hib_next[k])) hib_next[k] = pb[k][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid4 <= 1'b0;
      done <= 1'b0;
    end else begin
      valid4 <= in_valid;
      done <= valid4;
    end
  end

  always_ff @(posedge clk) begin
    loa <= loa_next;
    hia <= hia_next;
    lob <= lob_next;
    hib <= hib_next;
  end

  logic [NUM_AXES-1:0] apart;
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      apart[k] = ($signed(lob[k]) > $signed(hia[k])) || ($signed(loa[k]) > $signed(hib[k]));
    end
  end

  always_ff @(posedge clk) begin
    hit <= ~|apart;
  end
endmodule

@@ rtl/orot_checker.sv @@
// Port-level checker for the overlap test core, with its bind.
module orot_checker
  import orot_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic signed [POS_W-1:0]  a_pos_x,
  input logic signed [POS_W-1:0]  a_pos_y,
  input logic signed [POS_W-1:0]  b_pos_x,
  input logic signed [POS_W-1:0]  b_pos_y,
  input logic                     done,
  input logic                     hit
);
  // Every strobe comes from a matching earlier request.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result strobe without matching request");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    ($past(start, LATENCY) && !$past(rst, LATENCY) && !$past(rst, 4) && !$past(rst, 3)
     && !$past(rst, 2) && !$past(rst, 1)) |-> done)
    else $error("request lost in pipeline");

  // Boxes that share an origin share a point and must report a hit.
  a_shared_origin: assert property (@(posedge clk) disable iff (rst)
    (done && $past(a_pos_x == b_pos_x && a_pos_y == b_pos_y, LATENCY)) |-> hit)
    else $error("shared origin reported as separated");

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
endmodule

bind oriented_rect_overlap_test_core orot_checker u_orot_checker (
  .clk, .rst, .start, .busy, .a_pos_x, .a_pos_y, .b_pos_x, .b_pos_y, .done, .hit
);
